### rtl/dual_motor_stall_guard_macros.svh
// Assertion macros for the dual motor stall guard.
// Each macro names a clock and an active-low reset, and takes its
// antecedent, its consequent and a message.
`ifndef DUAL_MOTOR_STALL_GUARD_MACROS_SVH
`define DUAL_MOTOR_STALL_GUARD_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DMSG_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DMSG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/dmsg_pkg.sv
// ----------------------------------------------------------------------------
// dmsg_pkg
// Shared constants and types of the dual motor stall guard: register
// indices, reset values of the limit registers and the limit bundle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dmsg_pkg;

    localparam int COUNT_BITS_DEF = 16;

    localparam int DUTY_W  = 17;
    localparam int SPEED_W = 16;
    localparam int PWM_W   = 16;
    localparam int SLIM_W  = 15;
    localparam int HOLD_W  = 16;
    localparam int GRACE_W = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PWM_LIMIT   = 2'd0,
        CFG_SPEED_LIMIT = 2'd1,
        CFG_HOLD_TICKS  = 2'd2,
        CFG_GRACE_TICKS = 2'd3
    } t_cfg_index;

    localparam logic [PWM_W-1:0]   PWM_LIMIT_RST   = 16'd8000;
    localparam logic [SLIM_W-1:0]  SPEED_LIMIT_RST = 15'd2500;
    localparam logic [HOLD_W-1:0]  HOLD_TICKS_RST  = 16'd500;
    localparam logic [GRACE_W-1:0] GRACE_TICKS_RST = 16'd200;

    typedef struct packed {
        logic [PWM_W-1:0]  pwm_limit;
        logic [SLIM_W-1:0] speed_limit;
        logic [HOLD_W-1:0] hold_ticks;
    } t_wheel_limits;

endpackage

### rtl/dmsg_wheel.sv
// ----------------------------------------------------------------------------
// dmsg_wheel
// Stall test of one wheel: checks for high drive at low speed and works out
// the next value of the wheel's saturating hold count and its trip flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dmsg_wheel #(
    parameter int COUNT_BITS = dmsg_pkg::COUNT_BITS_DEF
) (
    input  logic signed [dmsg_pkg::DUTY_W-1:0]  i_duty,
    input  logic signed [dmsg_pkg::SPEED_W-1:0] i_speed,
    input  logic [COUNT_BITS-1:0]               i_count,
    input  dmsg_pkg::t_wheel_limits             i_limits,
    output logic [COUNT_BITS-1:0]               o_count_next,
    output logic                                o_trip
);

    localparam int CmpBits = (COUNT_BITS > dmsg_pkg::HOLD_W) ? COUNT_BITS
                                                              : dmsg_pkg::HOLD_W;

    logic [dmsg_pkg::DUTY_W-1:0]  w_duty_mag;
    logic [dmsg_pkg::SPEED_W-1:0] w_speed_mag;
    logic                         w_high;
    logic                         w_slow;
    logic                         w_qualify;
    logic [COUNT_BITS-1:0]        w_count_inc;
    logic [CmpBits-1:0]           w_count_cmp;
    logic [CmpBits-1:0]           w_hold_cmp;

    // The most negative codes have magnitudes that still fit unsigned.
    assign w_duty_mag  = i_duty[dmsg_pkg::DUTY_W-1]
                       ? (dmsg_pkg::DUTY_W'(0) - $unsigned(i_duty)) : $unsigned(i_duty);
    assign w_speed_mag = i_speed[dmsg_pkg::SPEED_W-1]
                       ? (dmsg_pkg::SPEED_W'(0) - $unsigned(i_speed)) : $unsigned(i_speed);

    assign w_high    = w_duty_mag >= {1'b0, i_limits.pwm_limit};
    assign w_slow    = w_speed_mag < {1'b0, i_limits.speed_limit};
    assign w_qualify = w_high && w_slow;

    assign w_count_inc = (&i_count) ? i_count : (i_count + COUNT_BITS'(1));
    assign w_count_cmp = CmpBits'(w_count_inc);
    assign w_hold_cmp  = CmpBits'(i_limits.hold_ticks);

    assign o_count_next = w_qualify ? w_count_inc : '0;
    assign o_trip       = w_qualify && (w_count_cmp >= w_hold_cmp);

endmodule

### rtl/dual_motor_stall_guard.sv
// Pipeline: an accepted item is registered in the input stage; its result is
// registered in the result stage. Throughput: one item per cycle when not stalled.
// Back-pressure on the result side stalls both stages; the input side keeps
// taking items while the result register can move on.
// Reset (synchronous, active low) clears all guard state and loads the
// default limits.
// ----------------------------------------------------------------------------
// dual_motor_stall_guard
// Stall detector for a two-wheel drive with a startup grace period, per-wheel
// hold counters and a trip latch that holds until the drive is disabled.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "dual_motor_stall_guard_macros.svh"

module dual_motor_stall_guard #(
    parameter int COUNT_BITS = dmsg_pkg::COUNT_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // tdata: drive_enabled[0], left_duty[17:1], right_duty[34:18],
    //        left_speed[50:35], right_speed[66:51], zero pad [71:67]
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [dmsg_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // tdata: stop_request[0], stall_latched[1], zero pad [7:2]
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [dmsg_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [dmsg_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [dmsg_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    // Limit registers
    logic [dmsg_pkg::PWM_W-1:0]   r_pwm_limit;
    logic [dmsg_pkg::SLIM_W-1:0]  r_speed_limit;
    logic [dmsg_pkg::HOLD_W-1:0]  r_hold_ticks;
    logic [dmsg_pkg::GRACE_W-1:0] r_grace_ticks;

    // Input stage
    logic                                  r_in_valid;
    logic                                  r_in_enabled;
    logic signed [dmsg_pkg::DUTY_W-1:0]    r_in_left_duty;
    logic signed [dmsg_pkg::DUTY_W-1:0]    r_in_right_duty;
    logic signed [dmsg_pkg::SPEED_W-1:0]   r_in_left_speed;
    logic signed [dmsg_pkg::SPEED_W-1:0]   r_in_right_speed;

    // Guard state
    logic [COUNT_BITS-1:0]        r_left_count, n_left_count;
    logic [COUNT_BITS-1:0]        r_right_count, n_right_count;
    logic [dmsg_pkg::GRACE_W-1:0] r_grace_count, n_grace_count;
    logic                         r_tripped, n_tripped;
    logic                         r_was_enabled, n_was_enabled;

    // Result stage
    logic r_out_valid;
    logic r_out_stop, n_out_stop;
    logic r_out_latched, n_out_latched;

    logic                         w_advance;
    logic                         w_fire;
    logic [dmsg_pkg::GRACE_W-1:0] w_grace_base;
    dmsg_pkg::t_wheel_limits      w_limits;
    logic [COUNT_BITS-1:0]        w_left_next, w_right_next;
    logic                         w_left_trip, w_right_trip;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pwm_limit   <= dmsg_pkg::PWM_LIMIT_RST;
            r_speed_limit <= dmsg_pkg::SPEED_LIMIT_RST;
            r_hold_ticks  <= dmsg_pkg::HOLD_TICKS_RST;
            r_grace_ticks <= dmsg_pkg::GRACE_TICKS_RST;
        end else if (i_cfg_valid) begin
            unique case (dmsg_pkg::t_cfg_index'(i_cfg_index))
                dmsg_pkg::CFG_PWM_LIMIT:   r_pwm_limit   <= i_cfg_data;
                dmsg_pkg::CFG_SPEED_LIMIT: r_speed_limit <= i_cfg_data[dmsg_pkg::SLIM_W-1:0];
                dmsg_pkg::CFG_HOLD_TICKS:  r_hold_ticks  <= i_cfg_data;
                dmsg_pkg::CFG_GRACE_TICKS: r_grace_ticks <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_advance     = !r_out_valid || m_axis_tready;
    assign w_fire        = r_in_valid && w_advance;
    assign s_axis_tready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_enabled     <= s_axis_tdata[0];
            r_in_left_duty   <= s_axis_tdata[17:1];
            r_in_right_duty  <= s_axis_tdata[34:18];
            r_in_left_speed  <= s_axis_tdata[50:35];
            r_in_right_speed <= s_axis_tdata[66:51];
        end
    end

    assign w_limits = '{pwm_limit:   r_pwm_limit,
                        speed_limit: r_speed_limit,
                        hold_ticks:  r_hold_ticks};

    dmsg_wheel #(.COUNT_BITS(COUNT_BITS)) u_left (
        .i_duty       (r_in_left_duty),
        .i_speed      (r_in_left_speed),
        .i_count      (r_left_count),
        .i_limits     (w_limits),
        .o_count_next (w_left_next),
        .o_trip       (w_left_trip)
    );

    dmsg_wheel #(.COUNT_BITS(COUNT_BITS)) u_right (
        .i_duty       (r_in_right_duty),
        .i_speed      (r_in_right_speed),
        .i_count      (r_right_count),
        .i_limits     (w_limits),
        .o_count_next (w_right_next),
        .o_trip       (w_right_trip)
    );

    // The grace count restarts on the first enabled tick after a disabled one.
    assign w_grace_base = r_was_enabled ? r_grace_count : '0;

    always_comb begin
        n_left_count  = r_left_count;
        n_right_count = r_right_count;
        n_grace_count = r_grace_count;
        n_tripped     = r_tripped;
        n_was_enabled = r_was_enabled;
        n_out_stop    = 1'b0;
        n_out_latched = 1'b0;
        priority if (!r_in_enabled) begin
            n_left_count  = '0;
            n_right_count = '0;
            n_grace_count = '0;
            n_tripped     = 1'b0;
            n_was_enabled = 1'b0;
        end else if (r_tripped) begin
            n_out_latched = 1'b1;
        end else if (w_grace_base < r_grace_ticks) begin
            n_was_enabled = 1'b1;
            n_grace_count = w_grace_base + dmsg_pkg::GRACE_W'(1);
            n_left_count  = '0;
            n_right_count = '0;
        end else if (w_left_trip || w_right_trip) begin
            n_was_enabled = 1'b1;
            n_grace_count = w_grace_base;
            n_tripped     = 1'b1;
            n_left_count  = '0;
            n_right_count = '0;
            n_out_stop    = 1'b1;
            n_out_latched = 1'b1;
        end else begin
            n_was_enabled = 1'b1;
            n_grace_count = w_grace_base;
            n_left_count  = w_left_next;
            n_right_count = w_right_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_count  <= '0;
            r_right_count <= '0;
            r_grace_count <= '0;
            r_tripped     <= 1'b0;
            r_was_enabled <= 1'b0;
        end else if (w_fire) begin
            r_left_count  <= n_left_count;
            r_right_count <= n_right_count;
            r_grace_count <= n_grace_count;
            r_tripped     <= n_tripped;
            r_was_enabled <= n_was_enabled;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_stop    <= n_out_stop;
            r_out_latched <= n_out_latched;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(dmsg_pkg::OUT_TDATA_W-2){1'b0}}, r_out_latched, r_out_stop};

    `DMSG_ASSERT_SAME(a_stop_implies_latched, i_clk, i_rst_n, r_out_valid && r_out_stop, r_out_latched, "stop request without latch")
    `DMSG_ASSERT_NEXT(a_trip_sets_latch, i_clk, i_rst_n, w_fire && n_out_stop, r_tripped, "trip did not set the latch")
    `DMSG_ASSERT_SAME(a_tripped_counts_clear, i_clk, i_rst_n, r_tripped, (r_left_count == '0) && (r_right_count == '0), "hold counts not clear while tripped")
    `DMSG_ASSERT_SAME(a_trip_needs_enable, i_clk, i_rst_n, !r_was_enabled, !r_tripped, "latch set while drive not enabled")

endmodule
